// ===== rtl/core/ttl_pkg.sv =====
package ttl_pkg;

   localparam int MAX_TOKEN_BYTES = 512;
   localparam int KEPT_W          = $clog2(MAX_TOKEN_BYTES);
   localparam int QUEUE_DEPTH     = 4;
   localparam int LINE_W          = 32;

   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_UNDER = 8'h5f;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   typedef enum logic [1:0] {
      EV_BYTE = 2'd0,
      EV_END  = 2'd1,
      EV_EOI  = 2'd2,
      EV_ERR  = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      CL_SYM = 2'd0,
      CL_ID  = 2'd1,
      CL_NUM = 2'd2,
      CL_STR = 2'd3
   } class_type;

   typedef struct packed {
      event_type  ev;
      class_type  cls;
      logic [7:0] ch;
   } res_type;

   typedef struct packed {
      logic [1:0]        count;
      res_type [2:0]     slot;
      logic [LINE_W-1:0] line;
   } desc_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

// ===== rtl/core/ttl_req_if.sv =====
interface ttl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_input;

   modport source (output valid, output text_byte, output end_of_input, input ready);
   modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

// ===== rtl/core/ttl_rsp_if.sv =====
interface ttl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_res;
   logic [1:0]  token_class;
   logic [7:0]  token_char;
   logic [31:0] line_number;

   modport source (output valid, output event_res, output token_class, output token_char,
                   output line_number, input ready);
   modport sink   (input valid, input event_res, input token_class, input token_char,
                   input line_number, output ready);
endinterface

// ===== rtl/core/ttl_front.sv =====
module ttl_front (
   input  logic              clock,
   input  logic              reset,
   ttl_req_if.sink           req_chan,
   output logic              push_valid,
   output ttl_pkg::desc_type push_desc,
   input  logic              push_ready
);
   import ttl_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_NUM     = 3'd2,
      MODE_IDENT   = 3'd3,
      MODE_STR     = 3'd4
   } mode_type;

   localparam logic [KEPT_W-1:0] KEPT_LIMIT = KEPT_W'(MAX_TOKEN_BYTES - 1);
   localparam logic [KEPT_W-1:0] KEPT_ONE   = KEPT_W'(1);

   mode_type          mode_ff, mode_in;
   logic [KEPT_W-1:0] kept_ff, kept_in;
   logic [LINE_W-1:0] line_ff, line_in;
   desc_type          desc;

   mode_type          idle_mode;
   logic [KEPT_W-1:0] idle_kept;
   logic              idle_nl;
   logic [1:0]        idle_cnt;
   res_type           idle_s0, idle_s1;

   logic [7:0] c;
   logic       eoi;
   logic       accept;
   class_type  run_cls;
   logic       run_more;

   assign c      = req_chan.text_byte;
   assign eoi    = req_chan.end_of_input;
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = push_ready;
   assign push_valid = accept && (desc.count != 2'd0);
   assign push_desc  = desc;

   // byte handled between tokens
   always_comb begin
      idle_mode = MODE_IDLE;
      idle_kept = kept_ff;
      idle_nl   = 1'b0;
      idle_cnt  = 2'd0;
      idle_s0   = '{ev: EV_BYTE, cls: CL_SYM, ch: 8'h00};
      idle_s1   = '{ev: EV_END, cls: CL_SYM, ch: 8'h00};
      priority if (c == CHAR_HASH) begin
         idle_mode = MODE_COMMENT;
      end else if (is_space(c)) begin
         idle_nl = (c == CHAR_LF);
      end else if (is_digit(c)) begin
         idle_mode = MODE_NUM;
         idle_kept = KEPT_ONE;
         idle_cnt  = 2'd1;
         idle_s0   = '{ev: EV_BYTE, cls: CL_NUM, ch: c};
      end else if (is_alpha(c)) begin
         idle_mode = MODE_IDENT;
         idle_kept = KEPT_ONE;
         idle_cnt  = 2'd1;
         idle_s0   = '{ev: EV_BYTE, cls: CL_ID, ch: c};
      end else if (c == CHAR_QUOTE) begin
         idle_mode = MODE_STR;
         idle_kept = '0;
      end else begin
         idle_kept = KEPT_ONE;
         idle_cnt  = 2'd2;
         idle_s0   = '{ev: EV_BYTE, cls: CL_SYM, ch: c};
      end
   end

   assign run_cls  = (mode_ff == MODE_NUM) ? CL_NUM : CL_ID;
   assign run_more = !eoi && ((mode_ff == MODE_NUM) ? is_digit(c)
                     : (is_alpha(c) || is_digit(c) || (c == CHAR_UNDER)));

   always_comb begin
      mode_in    = mode_ff;
      kept_in    = kept_ff;
      line_in    = line_ff;
      desc.count = 2'd0;
      desc.slot  = '0;
      desc.line  = line_ff;
      unique case (mode_ff)
         MODE_COMMENT: begin
            if (eoi) begin
               mode_in      = MODE_IDLE;
               desc.count   = 2'd1;
               desc.slot[0] = '{ev: EV_EOI, cls: CL_SYM, ch: 8'h00};
            end else if (c == CHAR_LF) begin
               line_in = line_ff + 32'd1;
               mode_in = MODE_IDLE;
            end
            desc.line = line_in;
         end
         MODE_NUM, MODE_IDENT: begin
            if (run_more) begin
               if (kept_ff < KEPT_LIMIT) begin
                  kept_in      = kept_ff + KEPT_ONE;
                  desc.count   = 2'd1;
                  desc.slot[0] = '{ev: EV_BYTE, cls: run_cls, ch: c};
               end
            end else begin
               desc.slot[0] = '{ev: EV_END, cls: run_cls, ch: 8'h00};
               if (eoi) begin
                  mode_in      = MODE_IDLE;
                  desc.count   = 2'd2;
                  desc.slot[1] = '{ev: EV_EOI, cls: CL_SYM, ch: 8'h00};
               end else begin
                  mode_in      = idle_mode;
                  kept_in      = idle_kept;
                  line_in      = line_ff + {31'd0, idle_nl};
                  desc.count   = 2'd1 + idle_cnt;
                  desc.slot[1] = idle_s0;
                  desc.slot[2] = idle_s1;
               end
            end
            // token end carries the count before a newline that follows it
            desc.line = line_ff;
         end
         MODE_STR: begin
            if (eoi || (c == CHAR_CR) || (c == CHAR_LF)) begin
               line_in      = line_ff + {31'd0, (!eoi && (c == CHAR_LF))};
               mode_in      = MODE_IDLE;
               desc.count   = 2'd1;
               desc.slot[0] = '{ev: EV_ERR, cls: CL_STR, ch: 8'h00};
            end else if (c == CHAR_QUOTE) begin
               mode_in      = MODE_IDLE;
               desc.count   = 2'd1;
               desc.slot[0] = '{ev: EV_END, cls: CL_STR, ch: 8'h00};
            end else if (kept_ff < KEPT_LIMIT) begin
               kept_in      = kept_ff + KEPT_ONE;
               desc.count   = 2'd1;
               desc.slot[0] = '{ev: EV_BYTE, cls: CL_STR, ch: c};
            end
            desc.line = line_in;
         end
         default: begin
            mode_in = MODE_IDLE;
            if (eoi) begin
               desc.count   = 2'd1;
               desc.slot[0] = '{ev: EV_EOI, cls: CL_SYM, ch: 8'h00};
            end else begin
               mode_in      = idle_mode;
               kept_in      = idle_kept;
               line_in      = line_ff + {31'd0, idle_nl};
               desc.count   = idle_cnt;
               desc.slot[0] = idle_s0;
               desc.slot[1] = idle_s1;
            end
            desc.line = line_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         kept_ff <= '0;
         line_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         kept_ff <= kept_in;
         line_ff <= line_in;
      end
   end

   a_eoi_idle: assert property (@(posedge clock) disable iff (reset)
      accept && eoi |=> mode_ff == MODE_IDLE)
      else $error("end of input left the scanner inside a token");

   a_line_step: assert property (@(posedge clock) disable iff (reset)
      line_ff == $past(line_ff) || line_ff == $past(line_ff) + 32'd1)
      else $error("line count moved by more than one");

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= KEPT_LIMIT)
      else $error("kept length beyond the token limit");

endmodule

// ===== rtl/core/ttl_queue.sv =====
module ttl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  ttl_pkg::desc_type push_desc,
   output logic              push_ready,
   output logic              pop_valid,
   output ttl_pkg::desc_type pop_desc,
   input  logic              pop
);
   import ttl_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, rd_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue holds more than its depth");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> count_ff == '0)
      else $error("queue not empty after reset");

endmodule

// ===== rtl/core/ttl_back.sv =====
module ttl_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  ttl_pkg::desc_type head_desc,
   output logic              head_pop,
   ttl_rsp_if.source         rsp_chan
);
   import ttl_pkg::*;

   res_type           out_ff;
   logic [LINE_W-1:0] line_ff;
   logic              valid_ff;
   logic [1:0]        idx_ff;
   logic              load;
   logic              last;

   assign load     = head_valid && (!valid_ff || rsp_chan.ready);
   assign last     = (idx_ff == (head_desc.count - 2'd1));
   assign head_pop = load && last;

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.event_res   = out_ff.ev;
   assign rsp_chan.token_class = out_ff.cls;
   assign rsp_chan.token_char  = out_ff.ch;
   assign rsp_chan.line_number = line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff  <= head_desc.slot[idx_ff];
         line_ff <= head_desc.line;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff < head_desc.count)
      else $error("slot index past the request's result count");

   a_idx_rewind: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> idx_ff == 2'd0)
      else $error("slot index not rewound after the last result");

endmodule

// ===== rtl/core/text_token_lexer_core.sv =====
// Streaming text lexer: each request carries one text byte or an end-of-input mark, and the
// block answers with token bytes, token ends, end-of-input and unterminated-string events, each
// tagged with the running newline count. Whitespace and '#' comments are skipped, tokens longer
// than MAX_TOKEN_BYTES-1 bytes are cut short. The front stage classifies a request
// and queues its results (up to three) in a four-entry queue; the back stage drives one result
// per cycle through a registered output while the receiver is ready. A request is thus taken
// every cycle while the queue has room, and the sustained rate is set by the output register,
// which sends the results of each request out one by one, up to three for a symbol that ends a
// number or identifier. Results pass through the queue and then the output register.
module text_token_lexer_core (
   input  logic      clock,
   input  logic      reset,
   ttl_req_if.sink   req_chan,
   ttl_rsp_if.source rsp_chan
);
   import ttl_pkg::*;

   logic     push_valid, push_ready;
   desc_type push_desc;
   logic     head_valid, head_pop;
   desc_type head_desc;

   ttl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .push_ready (push_ready)
   );

   ttl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .push_ready (push_ready),
      .pop_valid  (head_valid),
      .pop_desc   (head_desc),
      .pop        (head_pop)
   );

   ttl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ttl_pkg::*;

   typedef enum logic [2:0] {
      SCAN_IDLE    = 3'd0,
      SCAN_COMMENT = 3'd1,
      SCAN_NUM     = 3'd2,
      SCAN_IDENT   = 3'd3,
      SCAN_STR     = 3'd4
   } scan_type;

   typedef struct {
      logic [7:0] text_byte;
      logic       end_of_input;
   } text_req_type;

   typedef struct {
      event_type   ev;
      class_type   cls;
      logic [7:0]  ch;
      logic [31:0] line;
   } token_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ttl_req_if req_chan ();
   ttl_rsp_if rsp_chan ();

   text_token_lexer_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   text_req_type    pending_text[$];
   token_event_type token_events[$];
   text_req_type    next_req;
   token_event_type seen_event;

   scan_type    scan_mode;
   int unsigned kept_bytes;
   logic [31:0] line_total;

   int unsigned total_items    = 0;
   int unsigned accepted_count = 0;
   int unsigned fail_count     = 0;
   int unsigned hold_left;
   logic        hold_done;
   int unsigned random_start;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // character classes
   function automatic logic digit_char(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic letter_char(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic blank_char(logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function void push_event(event_type ev, class_type cls, logic [7:0] ch);
      token_events.push_back('{ev: ev, cls: cls, ch: ch, line: line_total});
   endfunction

   function void keep_char(class_type cls, logic [7:0] c);
      if (kept_bytes < MAX_TOKEN_BYTES - 1) begin
         kept_bytes++;
         push_event(EV_BYTE, cls, c);
      end
   endfunction

   function void start_token(logic [7:0] c);
      if (c == CHAR_HASH) begin
         scan_mode = SCAN_COMMENT;
      end else if (blank_char(c)) begin
         if (c == CHAR_LF) line_total++;
         scan_mode = SCAN_IDLE;
      end else if (digit_char(c)) begin
         scan_mode  = SCAN_NUM;
         kept_bytes = 0;
         keep_char(CL_NUM, c);
      end else if (letter_char(c)) begin
         scan_mode  = SCAN_IDENT;
         kept_bytes = 0;
         keep_char(CL_ID, c);
      end else if (c == CHAR_QUOTE) begin
         scan_mode  = SCAN_STR;
         kept_bytes = 0;
      end else begin
         scan_mode  = SCAN_IDLE;
         kept_bytes = 1;
         push_event(EV_BYTE, CL_SYM, c);
         push_event(EV_END, CL_SYM, 8'h00);
      end
   endfunction

   function void lex_text(logic [7:0] c, logic eoi);
      class_type cls;
      logic      more;
      case (scan_mode)
         SCAN_COMMENT: begin
            if (eoi) begin
               scan_mode = SCAN_IDLE;
               push_event(EV_EOI, CL_SYM, 8'h00);
            end else if (c == CHAR_LF) begin
               line_total++;
               scan_mode = SCAN_IDLE;
            end
         end
         SCAN_NUM, SCAN_IDENT: begin
            cls = (scan_mode == SCAN_NUM) ? CL_NUM : CL_ID;
            if (cls == CL_NUM) more = !eoi && digit_char(c);
            else more = !eoi && (letter_char(c) || digit_char(c) || c == CHAR_UNDER);
            if (more) begin
               keep_char(cls, c);
            end else begin
               push_event(EV_END, cls, 8'h00);
               scan_mode = SCAN_IDLE;
               if (eoi) push_event(EV_EOI, CL_SYM, 8'h00);
               else start_token(c);
            end
         end
         SCAN_STR: begin
            if (eoi || c == CHAR_CR || c == CHAR_LF) begin
               if (!eoi && c == CHAR_LF) line_total++;
               scan_mode = SCAN_IDLE;
               push_event(EV_ERR, CL_STR, 8'h00);
            end else if (c == CHAR_QUOTE) begin
               scan_mode = SCAN_IDLE;
               push_event(EV_END, CL_STR, 8'h00);
            end else begin
               keep_char(CL_STR, c);
            end
         end
         default: begin
            scan_mode = SCAN_IDLE;
            if (eoi) push_event(EV_EOI, CL_SYM, 8'h00);
            else start_token(c);
         end
      endcase
   endfunction

   // stimulus helpers
   function void add_char(logic [7:0] c);
      pending_text.push_back('{text_byte: c, end_of_input: 1'b0});
   endfunction

   function void add_eoi();
      pending_text.push_back('{text_byte: 8'($urandom_range(255)), end_of_input: 1'b1});
   endfunction

   function automatic logic [7:0] pick_letter();
      return $urandom_range(1) ? 8'($urandom_range("z", "a")) : 8'($urandom_range("Z", "A"));
   endfunction

   function automatic logic [7:0] pick_ident_tail();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (!(letter_char(c) || digit_char(c) || c == CHAR_UNDER));
      return c;
   endfunction

   function automatic logic [7:0] pick_string_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == CHAR_QUOTE || c == CHAR_CR || c == CHAR_LF);
      return c;
   endfunction

   function automatic logic [7:0] pick_symbol();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (letter_char(c) || digit_char(c) || blank_char(c) || c == CHAR_QUOTE ||
             c == CHAR_HASH);
      return c;
   endfunction

   function automatic logic [7:0] pick_blank();
      int unsigned r;
      r = $urandom_range(5);
      return (r == 5) ? CHAR_SPACE : 8'(CHAR_TAB + r);
   endfunction

   function automatic int unsigned sender_idle_pct();
      if (accepted_count < total_items / 3) return 30;
      if (accepted_count < 2 * total_items / 3) return 53;
      return 0;
   endfunction

   function automatic int unsigned receiver_idle_pct();
      if (accepted_count < total_items / 3) return 53;
      if (accepted_count < 2 * total_items / 3) return 30;
      return 0;
   endfunction

   function void add_random_sequence();
      int unsigned kind;
      int unsigned n;
      int unsigned r;
      kind = $urandom_range(99);
      if (kind < 20) begin
         n = $urandom_range(5, 1);
         repeat (n) add_char(8'($urandom_range("9", "0")));
      end else if (kind < 40) begin
         add_char(pick_letter());
         n = $urandom_range(6);
         repeat (n) add_char(pick_ident_tail());
      end else if (kind < 55) begin
         add_char(CHAR_QUOTE);
         n = $urandom_range(6);
         repeat (n) add_char(pick_string_char());
         r = $urandom_range(9);
         if (r == 0) add_char(CHAR_CR);
         else if (r == 1) add_char(CHAR_LF);
         else if (r == 2) add_eoi();
         else add_char(CHAR_QUOTE);
      end else if (kind < 63) begin
         add_char(CHAR_HASH);
         n = $urandom_range(5);
         repeat (n) begin
            do r = $urandom_range(255);
            while (r == CHAR_LF);
            add_char(8'(r));
         end
         if ($urandom_range(5) == 0) add_eoi();
         else add_char(CHAR_LF);
      end else if (kind < 75) begin
         n = $urandom_range(3, 1);
         repeat (n) add_char(pick_blank());
      end else if (kind < 88) begin
         add_char(8'($urandom_range(255)));
      end else if (kind < 92) begin
         add_eoi();
      end else begin
         add_char(pick_symbol());
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid        <= 1'b0;
         req_chan.text_byte    <= 8'h00;
         req_chan.end_of_input <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            lex_text(req_chan.text_byte, req_chan.end_of_input);
            accepted_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_text.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
               next_req = pending_text.pop_front();
               req_chan.valid        <= 1'b1;
               req_chan.text_byte    <= next_req.text_byte;
               req_chan.end_of_input <= next_req.end_of_input;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the internal queue fills up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_count >= 2 * total_items / 3 + 8) begin
         hold_left <= 60;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (token_events.size() == 0) begin
               $error("unexpected result: event_res %0d token_class %0d token_char %h",
                      rsp_chan.event_res, rsp_chan.token_class, rsp_chan.token_char);
               fail_count++;
            end else begin
               seen_event = token_events.pop_front();
               if (rsp_chan.event_res !== seen_event.ev) begin
                  $error("event_res mismatch: expected %0d, actual %0d",
                         seen_event.ev, rsp_chan.event_res);
                  fail_count++;
               end
               if (rsp_chan.token_class !== seen_event.cls) begin
                  $error("token_class mismatch: expected %0d, actual %0d",
                         seen_event.cls, rsp_chan.token_class);
                  fail_count++;
               end
               if (rsp_chan.token_char !== seen_event.ch) begin
                  $error("token_char mismatch: expected %h, actual %h",
                         seen_event.ch, rsp_chan.token_char);
                  fail_count++;
               end
               if (rsp_chan.line_number !== seen_event.line) begin
                  $error("line_number mismatch: expected %0d, actual %0d",
                         seen_event.line, rsp_chan.line_number);
                  fail_count++;
               end
            end
         end
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.text_byte    = 8'h00;
      req_chan.end_of_input = 1'b0;
      rsp_chan.ready        = 1'b0;
      scan_mode  = SCAN_IDLE;
      kept_bytes = 0;
      line_total = 32'd0;

      // identifier ended by a symbol, number ended by a high byte
      add_char("A");
      add_char("z");
      add_char(CHAR_UNDER);
      add_char("9");
      add_char("+");
      add_char("0");
      add_char("9");
      add_char(8'hff);
      // empty string, string with a zero byte, strings broken by lf and cr
      add_char(CHAR_QUOTE);
      add_char(CHAR_QUOTE);
      add_char(CHAR_QUOTE);
      add_char(8'h00);
      add_char(CHAR_QUOTE);
      add_char(CHAR_QUOTE);
      add_char(CHAR_LF);
      add_char(CHAR_QUOTE);
      add_char(CHAR_CR);
      // comment to end of line, whitespace, number cut by end of input
      add_char(CHAR_HASH);
      add_char(8'h80);
      add_char(CHAR_LF);
      add_char(CHAR_TAB);
      add_char("5");
      add_eoi();
      // string cut by end of input, comment cut by end of input, repeated mark
      add_char(CHAR_QUOTE);
      add_eoi();
      add_char(CHAR_HASH);
      add_eoi();
      add_eoi();

      // tokens past the length limit
      add_char(CHAR_QUOTE);
      repeat (520) add_char(pick_string_char());
      add_char(CHAR_QUOTE);
      add_char(pick_letter());
      repeat (515) add_char(pick_ident_tail());
      add_char(CHAR_SPACE);

      random_start = pending_text.size();
      while (pending_text.size() - random_start < 360) add_random_sequence();
      total_items = pending_text.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != total_items) @(posedge clock);
      while (token_events.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
